>>> sv/luminance_histogram_core_defines.svh
// Assertion macros shared by the histogram core modules.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef LUMINANCE_HISTOGRAM_CORE_DEFINES_SVH
`define LUMINANCE_HISTOGRAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lh_pkg.sv
// Shared types and constants of the luminance histogram core.
// No dependencies.
package lh_pkg;

    localparam int NUM_THRESH  = 7;
    localparam int SEL_W       = 3;
    localparam int OUT_COUNT_W = 24;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int NB_W        = 4;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 10;
    localparam int PROD_W      = 20;

    // brightness = sum / 3 as (sum * 683) >> 11, exact for sum <= 765
    localparam logic [PROD_W-1:0] RECIP_3     = 20'd683;
    localparam int                RECIP_SHIFT = 11;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    typedef logic [1:0] t_op;
    localparam t_op OP_COUNT = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;
    localparam t_op OP_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_N_BUCKETS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FIRST = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LAST  = 4'd7;

    localparam logic [NB_W-1:0]   NB_RESET = 4'd8;
    localparam logic [CHAN_W-1:0] THR_RESET [NUM_THRESH] =
        '{8'd31, 8'd63, 8'd95, 8'd127, 8'd159, 8'd191, 8'd223};

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Classified command, front to back
    typedef struct packed {
        t_op              op;
        logic [SEL_W-1:0] bucket;
    } t_cmd;

    // Read result, back to output queue
    typedef struct packed {
        logic [SEL_W-1:0]       idx;
        logic [OUT_COUNT_W-1:0] cnt;
    } t_res;

endpackage

>>> sv/luminance_histogram_core.sv
// Luminance histogram core: top level joining front end, command queue,
// back end and result queue. Depends on lh_pkg, lh_front, lh_fifo, lh_back.
//
// Use:
//  - Input words (i_op, i_blue, i_green, i_red, i_bucket_select) are taken at
//    an edge with push high and full low. op 0 counts a pixel in the bucket
//    of its brightness (channel sum / 3), op 1 reads one bucket's count,
//    op 2 clears all counts, op 3 is dropped.
//  - Only reads give a result word (o_bucket_index, o_bucket_count), shown
//    while empty is low and taken at an edge with pop high.
//  - Config words (i_cfg_index, i_cfg_data) are taken whenever i_cfg_valid is
//    high; o_cfg_ready is always high. Index 0 is the bucket count, 1..7 the
//    thresholds; other indices are ignored. Write only while idle.
//  - Throughput: one word per cycle while full is low, set by the back end,
//    which updates a counter for each command it pops. A read passes the
//    input stage, command queue and result queue to reach the result ports.
//  - A stalled result side fills the two-word result queue, then the
//    four-word command queue, then the input stage, after which full rises.
//    Counts and clears keep flowing until a read finds the result queue full.
//  - Synchronous reset clears all counts and queues and restores the default
//    eight buckets of width 32.
module luminance_histogram_core #(
    parameter int MAX_BUCKETS = 8,
    parameter int COUNT_BITS  = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input queue side
    input  logic                             push,
    output logic                             full,
    input  lh_pkg::t_op                      i_op,
    input  logic [lh_pkg::CHAN_W-1:0]        i_blue,
    input  logic [lh_pkg::CHAN_W-1:0]        i_green,
    input  logic [lh_pkg::CHAN_W-1:0]        i_red,
    input  logic [lh_pkg::SEL_W-1:0]         i_bucket_select,
    // result queue side
    output logic                             empty,
    input  logic                             pop,
    output logic [lh_pkg::SEL_W-1:0]         o_bucket_index,
    output logic [lh_pkg::OUT_COUNT_W-1:0]   o_bucket_count
);
    import lh_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

    t_cfg_wr w_cfg;
    // front to command queue
    logic    w_cmd_push;
    t_cmd    w_cmd_in;
    logic    w_cmd_full;
    // command queue to back
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    t_cmd    w_cmd_out;
    // back to result queue
    logic    w_res_push;
    t_res    w_res_in;
    logic    w_res_full;
    t_res    w_res_out;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    lh_front #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_op            (i_op),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .i_bucket_select (i_bucket_select),
        .o_cmd_push      (w_cmd_push),
        .o_cmd           (w_cmd_in),
        .i_cmd_full      (w_cmd_full)
    );

    // decouples classification from counter update
    lh_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    lh_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_full  (w_res_full)
    );

    // output register pair; parts back end from the receiver
    lh_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_out),
        .o_empty (empty)
    );

    assign o_bucket_index = w_res_out.idx;
    assign o_bucket_count = w_res_out.cnt;

endmodule

>>> sv/lh_fifo.sv
// Small register-based word queue, used for commands and results.
// Depends on luminance_histogram_core_defines.svh.
`include "luminance_histogram_core_defines.svh"

module lh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rdata   = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `LH_ASSERT_IMPL(a_cnt_range, 1'b1, r_count <= CW'(DEPTH), "fifo count beyond depth")
    `LH_ASSERT_NEXT(a_cnt_up, w_do_push && !w_do_pop, r_count == $past(r_count) + CW'(1), "fifo count did not rise on push")

endmodule

>>> sv/lh_front.sv
// Front end: config registers, input stage, brightness and bucket classification.
// Depends on lh_pkg and luminance_histogram_core_defines.svh.
`include "luminance_histogram_core_defines.svh"

module lh_front #(
    parameter int MAX_BUCKETS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lh_pkg::t_cfg_wr            i_cfg,
    input  logic                       i_push,
    output logic                       o_full,
    input  lh_pkg::t_op                i_op,
    input  logic [lh_pkg::CHAN_W-1:0]  i_blue,
    input  logic [lh_pkg::CHAN_W-1:0]  i_green,
    input  logic [lh_pkg::CHAN_W-1:0]  i_red,
    input  logic [lh_pkg::SEL_W-1:0]   i_bucket_select,
    output logic                       o_cmd_push,
    output lh_pkg::t_cmd               o_cmd,
    input  logic                       i_cmd_full
);
    import lh_pkg::*;

    logic [NB_W-1:0]   r_n_buckets;
    logic [CHAN_W-1:0] r_thr [NUM_THRESH];

    logic              r_valid;
    t_op               r_op;
    logic [CHAN_W-1:0] r_bright;
    logic [SEL_W-1:0]  r_sel;

    logic [SUM_W-1:0]  w_sum;
    logic [PROD_W-1:0] w_prod;
    logic [NB_W-1:0]   w_nb;
    logic [SEL_W-1:0]  w_bucket;
    logic              w_accept;
    logic              w_stage_out;

    // config writes; ready is tied high at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_buckets <= NB_RESET;
            for (int k = 0; k < NUM_THRESH; k++) begin
                r_thr[k] <= THR_RESET[k];
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_N_BUCKETS) begin
                r_n_buckets <= i_cfg.data[NB_W-1:0];
            end else if (i_cfg.index >= CFG_THR_FIRST && i_cfg.index <= CFG_THR_LAST) begin
                r_thr[3'(i_cfg.index - CFG_THR_FIRST)] <= i_cfg.data;
            end
        end
    end

    // brightness by reciprocal multiply
    assign w_sum  = SUM_W'(i_blue) + SUM_W'(i_green) + SUM_W'(i_red);
    assign w_prod = PROD_W'(w_sum) * RECIP_3;

    assign w_stage_out = r_valid && (r_op == OP_NOP || !i_cmd_full);
    assign o_full      = r_valid && !w_stage_out;
    assign w_accept    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_stage_out) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_bright <= w_prod[RECIP_SHIFT +: CHAN_W];
            r_sel    <= i_bucket_select;
        end
    end

    // effective bucket count, then lowest matching threshold wins
    always_comb begin
        w_nb = r_n_buckets;
        if (r_n_buckets == '0) begin
            w_nb = NB_W'(1);
        end else if (r_n_buckets > NB_W'(MAX_BUCKETS)) begin
            w_nb = NB_W'(MAX_BUCKETS);
        end
        w_bucket = SEL_W'(w_nb - NB_W'(1));
        for (int k = NUM_THRESH; k >= 1; k--) begin
            if (NB_W'(k) < w_nb && r_bright <= r_thr[k-1]) begin
                w_bucket = SEL_W'(k - 1);
            end
        end
    end

    assign o_cmd_push  = r_valid && (r_op != OP_NOP) && !i_cmd_full;
    assign o_cmd.op     = r_op;
    assign o_cmd.bucket = (r_op == OP_READ) ? r_sel : w_bucket;

    `LH_ASSERT_NEXT(a_stage_load, w_accept, r_valid, "accepted word missing from stage")

endmodule

>>> sv/lh_back.sv
// Back end: bucket counters, saturating increment, clear and read-out.
// Depends on lh_pkg and luminance_histogram_core_defines.svh.
`include "luminance_histogram_core_defines.svh"

module lh_back #(
    parameter int MAX_BUCKETS = 8,
    parameter int COUNT_BITS  = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  lh_pkg::t_cmd  i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_push,
    output lh_pkg::t_res  o_res,
    input  logic          i_res_full
);
    import lh_pkg::*;

    logic [COUNT_BITS-1:0] r_counts [MAX_BUCKETS];
    logic [COUNT_BITS-1:0] w_sel_cnt;
    logic [31:0]           w_cnt_wide;
    logic                  w_any_count;

    // a read waits for room in the result queue
    assign o_cmd_pop  = !i_cmd_empty && (i_cmd.op != OP_READ || !i_res_full);
    assign o_res_push = o_cmd_pop && (i_cmd.op == OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BUCKETS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (o_cmd_pop) begin
            unique case (i_cmd.op)
                OP_CLEAR: begin
                    for (int i = 0; i < MAX_BUCKETS; i++) begin
                        r_counts[i] <= '0;
                    end
                end
                OP_COUNT: begin
                    for (int i = 0; i < MAX_BUCKETS; i++) begin
                        if (i_cmd.bucket == SEL_W'(i) && r_counts[i] != '1) begin
                            r_counts[i] <= r_counts[i] + COUNT_BITS'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // select beyond MAX_BUCKETS reads as zero
    always_comb begin
        w_sel_cnt   = '0;
        w_any_count = 1'b0;
        for (int i = 0; i < MAX_BUCKETS; i++) begin
            if (i_cmd.bucket == SEL_W'(i)) begin
                w_sel_cnt = r_counts[i];
            end
            w_any_count = w_any_count | (|r_counts[i]);
        end
    end

    assign w_cnt_wide = 32'(w_sel_cnt);
    assign o_res.idx  = i_cmd.bucket;
    assign o_res.cnt  = w_cnt_wide[OUT_COUNT_W-1:0];

    `LH_ASSERT_NEXT(a_clear, o_cmd_pop && i_cmd.op == OP_CLEAR, !w_any_count, "counts not zero after clear")

endmodule

>>> verif/tb.sv
// Self-checking testbench for luminance_histogram_core: a bucket-count
// scoreboard class predicts every read word. Depends on lh_pkg and the core RTL.
class histo_scoreboard;
    typedef struct {
        logic [2:0]  idx;
        logic [23:0] cnt;
    } t_read_word;

    logic [3:0]  nb_setting;
    logic [7:0]  thr [7];
    logic [23:0] counts [8];
    t_read_word  awaited [$];
    int          errors;
    int          pixels;
    int          reads_checked;

    function new();
        errors        = 0;
        pixels        = 0;
        reads_checked = 0;
        nb_setting    = 4'd8;
        foreach (thr[i]) thr[i] = 8'(32 * i + 31);
        foreach (counts[i]) counts[i] = '0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [7:0] data);
        if (idx == lh_pkg::CFG_N_BUCKETS) begin
            nb_setting = data[3:0];
        end else if (idx <= lh_pkg::CFG_THR_LAST) begin
            thr[int'(idx) - 1] = data;
        end
    endfunction

    // zero acts as one bucket, anything past eight as eight
    function int active_buckets();
        if (nb_setting == 4'd0) return 1;
        if (nb_setting > 4'd8) return 8;
        return int'(nb_setting);
    endfunction

    // first threshold in ascending order that covers the brightness wins
    function int bucket_of(int bright);
        int nb;
        nb = active_buckets();
        for (int k = 1; k < nb && k <= 7; k++) begin
            if (bright <= int'(thr[k - 1])) return k - 1;
        end
        return nb - 1;
    endfunction

    function void note_word(lh_pkg::t_op op, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r, logic [2:0] sel);
        int         bkt;
        t_read_word w;
        case (op)
            lh_pkg::OP_COUNT: begin
                bkt = bucket_of((int'(b) + int'(g) + int'(r)) / 3);
                if (counts[bkt] != '1) counts[bkt] = counts[bkt] + 1'b1;
                pixels++;
            end
            lh_pkg::OP_READ: begin
                w.idx = sel;
                w.cnt = counts[sel];
                awaited = {awaited, w};
            end
            lh_pkg::OP_CLEAR: begin
                foreach (counts[i]) counts[i] = '0;
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [2:0] idx, logic [23:0] cnt);
        t_read_word w;
        if (awaited.size() == 0) begin
            $display("%0t: result word with none awaited: bucket %0d count %0d",
                     $time, idx, cnt);
            errors++;
            return;
        end
        w = awaited.pop_front();
        if (idx !== w.idx) begin
            $display("%0t: bucket_index mismatch: expected %0d, got %0d",
                     $time, w.idx, idx);
            errors++;
        end
        if (cnt !== w.cnt) begin
            $display("%0t: bucket_count mismatch (bucket %0d): expected %0d, got %0d",
                     $time, w.idx, w.cnt, cnt);
            errors++;
        end
        reads_checked++;
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb;
    import lh_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 16;   // covers counts still in the queues
    localparam int PHASES         = 9;
    localparam int PHASE_WORDS    = 180;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   push;
    logic                   full;
    t_op                    i_op;
    logic [CHAN_W-1:0]      i_blue;
    logic [CHAN_W-1:0]      i_green;
    logic [CHAN_W-1:0]      i_red;
    logic [SEL_W-1:0]       i_bucket_select;
    logic                   empty;
    logic                   pop;
    logic [SEL_W-1:0]       o_bucket_index;
    logic [OUT_COUNT_W-1:0] o_bucket_count;

    histo_scoreboard sb;
    bit              quiet    = 1'b0;  // no idling on either side
    bit              hold_req = 1'b0;  // asks the receiver for a long hold-off
    int              settings_used = 0;
    int              idle_cycles   = 0;

    luminance_histogram_core #(
        .MAX_BUCKETS (8),
        .COUNT_BITS  (24)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .i_bucket_select (i_bucket_select),
        .empty           (empty),
        .pop             (pop),
        .o_bucket_index  (o_bucket_index),
        .o_bucket_count  (o_bucket_count)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d read words outstanding",
                     $time, sb.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: pop driven on the falling edge, words checked on the rising
    // edge. Random stall bursts, or one long hold-off when asked.
    initial begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                pop = 1'b0;
                stall_left--;
            end else begin
                pop = 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_bucket_index, o_bucket_count);
        end
    end

    // Offer one word, with an optional idle burst first; returns at the edge
    // where it was taken. push is left high for a following word.
    task automatic send_word(t_op op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             logic [2:0] sel);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                push = 1'b0;
            end
        end
        @(negedge i_clk);
        push            = 1'b1;
        i_op            = op;
        i_blue          = b;
        i_green         = g;
        i_red           = r;
        i_bucket_select = sel;
        do @(posedge i_clk); while (full);
        sb.note_word(op, b, g, r, sel);
    endtask

    task automatic write_cfg(logic [3:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Stop offering, let every read word arrive, then give trailing counts
    // and clears time to leave the queues before registers change.
    task automatic settle();
        @(negedge i_clk);
        push = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // style: 0 even split, 1 all zero, 2 all 255, 3 sorted random, 4 unsorted
    task automatic program_setting(int unsigned nb, int style);
        logic [7:0] vals [7];
        logic [7:0] tmp;
        foreach (vals[i]) begin
            case (style)
                0:       vals[i] = 8'(32 * i + 31);
                1:       vals[i] = 8'h00;
                2:       vals[i] = 8'hFF;
                default: vals[i] = 8'($urandom);
            endcase
        end
        if (style == 3) begin
            for (int i = 0; i < 6; i++) begin
                for (int j = 0; j < 6 - i; j++) begin
                    if (vals[j] > vals[j + 1]) begin
                        tmp         = vals[j];
                        vals[j]     = vals[j + 1];
                        vals[j + 1] = tmp;
                    end
                end
            end
        end
        // upper nibble of the bucket-count word is junk and must be ignored
        write_cfg(CFG_N_BUCKETS, {4'($urandom), 4'(nb)});
        for (int i = 0; i < 7; i++) write_cfg(CFG_THR_FIRST + 4'(i), vals[i]);
        // index past the thresholds: no effect
        write_cfg(4'($urandom_range(int'(CFG_THR_LAST) + 1, 15)), 8'($urandom));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings_used++;
    endtask

    task automatic send_random();
        int unsigned roll;
        int unsigned v;
        int unsigned extra;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
        t_op         op;
        roll = $urandom_range(0, 99);
        b    = 8'($urandom);
        g    = 8'($urandom);
        r    = 8'($urandom);
        if (roll < 62) begin
            op = OP_COUNT;
            // a third of the pixels sit on or next to a threshold
            if ($urandom_range(0, 2) == 0) begin
                v     = int'(sb.thr[$urandom_range(0, 6)]) + $urandom_range(0, 2);
                v     = (v == 0) ? 0 : v - 1;
                v     = (v > 255) ? 255 : v;
                extra = $urandom_range(0, 2);
                b     = 8'(v);
                g     = 8'(v);
                r     = (v + extra <= 255) ? 8'(v + extra) : 8'(v);
            end
        end else if (roll < 88) begin
            op = OP_READ;
        end else if (roll < 91) begin
            op = OP_CLEAR;
        end else begin
            op = OP_NOP;
        end
        send_word(op, b, g, r, 3'($urandom));
    endtask

    initial begin
        int unsigned nb_plan    [PHASES];
        int          style_plan [PHASES];
        nb_plan    = '{8, 3, 0, 1, 15, 9, 2, 5, 8};
        style_plan = '{3, 4, 3, 2, 1, 4, 3, 4, 0};
        sb = new();
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_N_BUCKETS;
        i_cfg_data      = '0;
        push            = 1'b0;
        i_op            = OP_NOP;
        i_blue          = '0;
        i_green         = '0;
        i_red           = '0;
        i_bucket_select = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, on the reset thresholds: channel extremes, truncation of
        // the divide, both sides of a threshold, the top bucket, a dropped op,
        // every bucket read, then clear.
        send_word(OP_COUNT, 8'd0,   8'd0,   8'd0,   3'd0);
        send_word(OP_COUNT, 8'd255, 8'd255, 8'd255, 3'd7);
        send_word(OP_COUNT, 8'd31,  8'd31,  8'd31,  3'd0);
        send_word(OP_COUNT, 8'd32,  8'd31,  8'd31,  3'd0);  // 94/3 truncates to 31
        send_word(OP_COUNT, 8'd32,  8'd32,  8'd32,  3'd0);
        send_word(OP_COUNT, 8'd223, 8'd224, 8'd224, 3'd0);  // 671/3 = 223
        send_word(OP_COUNT, 8'd224, 8'd224, 8'd224, 3'd0);
        send_word(OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
        for (int i = 0; i < 8; i++) send_word(OP_READ, 8'hFF, 8'h00, 8'hAA, 3'(i));
        send_word(OP_CLEAR, 8'h55, 8'hAA, 8'hFF, 3'd5);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 3'd0);
        send_word(OP_READ, 8'd0, 8'd0, 8'd0, 3'd7);

        // Random phases, each under its own register setting: bucket counts
        // of zero, one, above eight, and thresholds at both extremes, sorted
        // and unsorted. Counts survive a change of bucket count, so reads of
        // unused buckets see earlier totals. The last phase runs without gaps.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            program_setting(nb_plan[p], style_plan[p]);
            quiet = (p == PHASES - 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == 20) begin
                    // back-pressure: receiver holds off while reads pile up
                    hold_req = 1'b1;
                    repeat (40) send_word(OP_READ, 8'($urandom), 8'($urandom),
                                          8'($urandom), 3'($urandom));
                end
                send_random();
            end
        end
        settle();

        $display("Covered %0d counted pixels and %0d checked bucket reads", sb.pixels,
                 sb.reads_checked);
        $display("over %0d register settings; %0d mismatches", settings_used + 1,
                 sb.errors);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> luminance_histogram_core.f
+incdir+sv
sv/lh_pkg.sv
sv/lh_fifo.sv
sv/lh_front.sv
sv/lh_back.sv
sv/luminance_histogram_core.sv
verif/tb.sv
